// ----- hw/rtl/fsd_pkg.sv -----
// Package for the sliding-DFT FSK bit detector.
// Holds fixed widths, bin part codes and the 2.12 twiddle tables; no dependencies.
package fsd_pkg;

    localparam int HIST_DEPTH = 24;
    localparam int HIST_AW    = 5;
    localparam int ACC_W      = 33;
    localparam int ABS_W      = ACC_W - 1;
    localparam int POW_W      = 64;
    localparam int COEF_W     = 14;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef enum logic [1:0] {
        BP_SPACE_RE = 2'd0,
        BP_SPACE_IM = 2'd1,
        BP_MARK_RE  = 2'd2,
        BP_MARK_IM  = 2'd3
    } t_bin_part;

    function automatic t_coef cos3(input logic [2:0] ph);
        t_coef c;
        case (ph)
            3'd0:    c = 14'sd4096;
            3'd1:    c = 14'sd2896;
            3'd2:    c = 14'sd0;
            3'd3:    c = -14'sd2896;
            3'd4:    c = -14'sd4096;
            3'd5:    c = -14'sd2896;
            3'd6:    c = 14'sd0;
            3'd7:    c = 14'sd2896;
            default: c = 14'sd0;
        endcase
        return c;
    endfunction

    function automatic t_coef sin3(input logic [2:0] ph);
        t_coef c;
        case (ph)
            3'd0:    c = 14'sd0;
            3'd1:    c = 14'sd2896;
            3'd2:    c = 14'sd4096;
            3'd3:    c = 14'sd2896;
            3'd4:    c = 14'sd0;
            3'd5:    c = -14'sd2896;
            3'd6:    c = -14'sd4096;
            3'd7:    c = -14'sd2896;
            default: c = 14'sd0;
        endcase
        return c;
    endfunction

    function automatic t_coef cos4(input logic [2:0] ph);
        t_coef c;
        case (ph)
            3'd0:    c = 14'sd4096;
            3'd1:    c = 14'sd2048;
            3'd2:    c = -14'sd2048;
            3'd3:    c = -14'sd4096;
            3'd4:    c = -14'sd2048;
            3'd5:    c = 14'sd2048;
            default: c = 14'sd0;
        endcase
        return c;
    endfunction

    function automatic t_coef sin4(input logic [2:0] ph);
        t_coef c;
        case (ph)
            3'd0:    c = 14'sd0;
            3'd1:    c = 14'sd3547;
            3'd2:    c = 14'sd3547;
            3'd3:    c = 14'sd0;
            3'd4:    c = -14'sd3547;
            3'd5:    c = -14'sd3547;
            default: c = 14'sd0;
        endcase
        return c;
    endfunction

    function automatic t_coef coef(input t_bin_part part, input logic [2:0] ph8,
                                   input logic [2:0] ph6);
        t_coef c;
        case (part)
            BP_SPACE_RE: c = cos3(ph8);
            BP_SPACE_IM: c = sin3(ph8);
            BP_MARK_RE:  c = cos4(ph6);
            BP_MARK_IM:  c = sin4(ph6);
            default:     c = 14'sd0;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/fsk_sliding_dft_bit_detector.sv -----
// Sliding-DFT FSK bit detector top level: history ring and accumulator memories,
// shared product/square pipeline and power compare. Uses fsd_pkg.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+---------------------------
//  sample   | i_sample_valid / o_sample_ready | i_sample (16b signed)
//  bit      | o_bit_valid / i_bit_ready       | o_decided_bit (1b)
//
// A sample is taken only while idle, then runs history read, difference,
// four accumulator read-modify-writes on the four-entry accumulator memory,
// a four-stage product/accumulate/abs/square drain, power sums, then the compare.
// Reset (synchronous, active low) clears control and all valid bits; memory
// entries without a valid bit read as zero. A result waiting on i_bit_ready
// does not block the next transfer; only the final compare holds for it.
module fsk_sliding_dft_bit_detector #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_sample_valid,
    output logic        o_sample_ready,
    input  logic [15:0] i_sample,
    output logic        o_bit_valid,
    input  logic        i_bit_ready,
    output logic        o_decided_bit
);

    localparam int YW = SAMPLE_WIDTH + 1;
    localparam int PW = YW + fsd_pkg::COEF_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIFF  = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [fsd_pkg::HIST_AW-1:0]          r_pos;
    logic [2:0]                           r_ph6;
    logic signed [SAMPLE_WIDTH-1:0]       r_x;
    logic signed [YW-1:0]                 r_y;
    fsd_pkg::t_bin_part                   r_k;

    logic signed [SAMPLE_WIDTH-1:0]       r_hist_mem [fsd_pkg::HIST_DEPTH];
    logic [fsd_pkg::HIST_DEPTH-1:0]       r_hist_vld;
    logic signed [SAMPLE_WIDTH-1:0]       r_hist_q;
    logic                                 r_hist_q_vld;

    logic signed [fsd_pkg::ACC_W-1:0]     r_acc_mem [4];
    logic [3:0]                           r_acc_vld;
    logic signed [fsd_pkg::ACC_W-1:0]     r_acc_q;
    logic                                 r_acc_q_vld;

    logic                                 r_v1, r_v2, r_v3, r_v4;
    fsd_pkg::t_bin_part                   r_k1, r_k2, r_k3, r_k4;
    logic signed [PW-1:0]                 r_prod;
    logic signed [fsd_pkg::ACC_W-1:0]     r_new;
    logic [fsd_pkg::ABS_W-1:0]            r_abs;
    logic [fsd_pkg::POW_W-1:0]            r_sq;
    logic [fsd_pkg::POW_W-1:0]            r_space_pow;
    logic [fsd_pkg::POW_W-1:0]            r_mark_pow;

    logic                                 r_out_valid;
    logic                                 r_out_bit;

    logic                                 w_in_xfer;
    logic                                 w_out_load;
    logic [fsd_pkg::HIST_AW-1:0]          w_hist_addr;
    logic [fsd_pkg::HIST_AW-1:0]          w_next_pos;
    logic [2:0]                           w_next_ph6;
    logic signed [SAMPLE_WIDTH-1:0]       w_x_new;
    logic signed [SAMPLE_WIDTH-1:0]       w_hist_rd;
    logic signed [fsd_pkg::ACC_W-1:0]     w_acc_rd;
    logic signed [fsd_pkg::ACC_W-1:0]     w_acc_sum;
    logic signed [fsd_pkg::ACC_W-1:0]     w_abs;
    fsd_pkg::t_coef                       w_coef;
    logic signed [PW-1:0]                 w_prod;
    logic [fsd_pkg::POW_W-1:0]            w_sq;

    assign o_sample_ready = (r_state == ST_IDLE);
    assign w_in_xfer      = i_sample_valid && o_sample_ready;
    assign w_out_load     = (r_state == ST_DONE) && (!r_out_valid || i_bit_ready);
    assign o_bit_valid    = r_out_valid;
    assign o_decided_bit  = r_out_bit;

    assign w_x_new     = signed'(i_sample[SAMPLE_WIDTH-1:0]);
    assign w_hist_addr = (r_pos >= fsd_pkg::HIST_AW'(fsd_pkg::HIST_DEPTH)) ? '0 : r_pos;
    assign w_next_pos  = (w_hist_addr == fsd_pkg::HIST_AW'(fsd_pkg::HIST_DEPTH - 1)) ?
                         '0 : w_hist_addr + 1'b1;
    assign w_next_ph6  = (w_next_pos == '0 || r_ph6 == 3'd5) ? 3'd0 : r_ph6 + 3'd1;

    assign w_hist_rd = r_hist_q_vld ? r_hist_q : '0;
    assign w_acc_rd  = r_acc_q_vld ? r_acc_q : '0;
    assign w_coef    = fsd_pkg::coef(r_k, r_pos[2:0], r_ph6);
    assign w_prod    = r_y * w_coef;
    assign w_acc_sum = w_acc_rd + fsd_pkg::ACC_W'(r_prod);
    assign w_abs     = r_new[fsd_pkg::ACC_W-1] ? -r_new : r_new;
    assign w_sq      = r_abs * r_abs;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_in_xfer) n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_ISSUE;
            ST_ISSUE: if (r_k == fsd_pkg::BP_MARK_IM) n_state = ST_DRAIN;
            ST_DRAIN: if (!(r_v1 || r_v2 || r_v3 || r_v4)) n_state = ST_DONE;
            ST_DONE:  if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // history ring: read old entry and write new sample in the same cycle
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_hist_q                <= r_hist_mem[w_hist_addr];
            r_hist_mem[w_hist_addr] <= w_x_new;
        end
    end

    // accumulator memory: read at issue, write back in the following cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ISSUE) begin
            r_acc_q <= r_acc_mem[r_k];
        end
        if (r_v1) begin
            r_acc_mem[r_k1] <= w_acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_x <= w_x_new;
        end
        if (r_state == ST_DIFF) begin
            r_y <= YW'(r_x) - YW'(w_hist_rd);
        end
        r_prod <= w_prod;
        r_k1   <= r_k;
        r_new  <= w_acc_sum;
        r_k2   <= r_k1;
        r_abs  <= w_abs[fsd_pkg::ABS_W-1:0];
        r_k3   <= r_k2;
        r_sq   <= w_sq;
        r_k4   <= r_k3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= '0;
            r_ph6        <= '0;
            r_k          <= fsd_pkg::BP_SPACE_RE;
            r_hist_vld   <= '0;
            r_hist_q_vld <= 1'b0;
            r_acc_vld    <= '0;
            r_acc_q_vld  <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_space_pow  <= '0;
            r_mark_pow   <= '0;
            r_out_valid  <= 1'b0;
            r_out_bit    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == ST_ISSUE);
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;

            if (w_in_xfer) begin
                r_hist_q_vld             <= r_hist_vld[w_hist_addr];
                r_hist_vld[w_hist_addr]  <= 1'b1;
                r_pos                    <= w_next_pos;
                r_ph6                    <= w_next_ph6;
                r_k                      <= fsd_pkg::BP_SPACE_RE;
                r_space_pow              <= '0;
                r_mark_pow               <= '0;
            end

            if (r_state == ST_ISSUE) begin
                r_acc_q_vld <= r_acc_vld[r_k];
                r_k         <= fsd_pkg::t_bin_part'(r_k + 2'd1);
            end
            if (r_v1) begin
                r_acc_vld[r_k1] <= 1'b1;
            end

            if (r_v4) begin
                if (r_k4 == fsd_pkg::BP_SPACE_RE || r_k4 == fsd_pkg::BP_SPACE_IM) begin
                    r_space_pow <= r_space_pow + r_sq;
                end else begin
                    r_mark_pow <= r_mark_pow + r_sq;
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_bit   <= (r_mark_pow >= r_space_pow);
            end else if (r_out_valid && i_bit_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
